FILE: rtl/core/md5_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and step tables of the MD5 digest unit.
// ----------------------------------------------------------------------------
package md5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} md5_in_t;

	typedef struct packed {
		logic [63:0] digest_low;
		logic [63:0] digest_high;
	} md5_out_t;

	// front-to-back request: one byte and/or an end mark
	typedef md5_in_t md5_req_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_LEN,
		ST_EMIT
	} md5_state_t;

	function automatic logic [31:0] step_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] step_rot(input logic [5:0] i);
		logic [4:0] r;
		unique case ({i[5:4], i[1:0]})
			4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
			4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
			4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/md5_message_digest_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 digest over a byte stream, one byte per request.
// ----------------------------------------------------------------------------
// The back end stores one byte request per cycle while it is idle, taking it
// from the queue register; every 64th byte starts a compression, one MD5 step
// per cycle in the round unit, during which no request is taken. A request
// with last set pads the block, writes the length, runs the compression and
// loads the digest into an output register, waiting there while the previous
// digest is still stalled; when no more than 8 bytes are left the padded block
// is compressed first, and a last byte that fills the block is compressed with
// that full block before the padding block.
// A two-entry queue in front lets requests land while the round unit works.
// Requests with neither a byte nor last are dropped.
module md5_message_digest_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  md5_pkg::md5_in_t    in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output md5_pkg::md5_out_t   out_data
);
	import md5_pkg::*;

	logic     req_valid, req_take;
	md5_req_t req_data;

	md5_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.req_valid(req_valid), .req_take(req_take), .req_data(req_data)
	);

	md5_back u_back (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_take(req_take), .req_data(req_data),
		.out_valid(out_valid), .stall(out_stall), .out_data(out_data)
	);

endmodule
`default_nettype wire

FILE: rtl/core/md5_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_front
// Input side: drops empty requests and queues the rest for the back end.
// ----------------------------------------------------------------------------
module md5_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  md5_pkg::md5_in_t    in_data,
	output logic                req_valid,
	input  wire                 req_take,
	output md5_pkg::md5_req_t   req_data
);
	import md5_pkg::*;

	// two-entry queue
	md5_req_t   slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop, keep;

	assign in_stall = (count_q == 2'd2);
	assign keep = in_data.byte_valid | in_data.last;
	assign push = in_valid & ~in_stall & keep;
	assign pop = req_take & req_valid;
	assign req_valid = (count_q != 2'd0);
	assign req_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> count_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: rtl/core/md5_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// md5_back
// Block buffer, padding sequencer and one-step-per-cycle MD5 round unit.
// ----------------------------------------------------------------------------
module md5_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_take,
	input  md5_pkg::md5_req_t   req_data,
	output logic                out_valid,
	input  wire                 stall,
	output md5_pkg::md5_out_t   out_data
);
	import md5_pkg::*;

	logic [31:0] buf_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  idx_q;
	logic        fin_q;     // end mark pending after this compression
	logic        len_q;     // this compression carries the length
	logic        tail_q;    // length block still to follow this compression
	logic        ov_q;
	md5_out_t    out_q;
	md5_state_t  state_q, state_d;

	logic [3:0]  g;
	logic [31:0] f, t, rot, bnew, m;
	logic [63:0] w;

	always_comb begin
		unique case (idx_q[5:4])
			2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = idx_q[3:0]; end
			2'd1: begin f = (b_q & d_q) | (c_q & ~d_q); g = 4'(5 * idx_q + 1); end
			2'd2: begin f = b_q ^ c_q ^ d_q; g = 4'(3 * idx_q + 5); end
			default: begin f = c_q ^ (b_q | ~d_q); g = 4'(7 * idx_q); end
		endcase
		m = buf_q[g];
		t = a_q + f + m + step_k(idx_q);
		w = {t, t} << step_rot(idx_q);
		rot = w[63:32];
		bnew = b_q + rot;
	end

	assign req_take = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_data = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid) begin
				if (req_data.byte_valid && fill_q == 6'd63) state_d = ST_ROUND;
				else if (req_data.last) state_d = ST_PAD;
			end
			ST_ROUND: if (idx_q == 6'd63) begin
				if (len_q) state_d = ST_EMIT;
				else if (fin_q) state_d = ST_PAD;
				else if (tail_q) state_d = ST_LEN;
				else state_d = ST_IDLE;
			end
			ST_PAD: state_d = (fill_q >= 6'd56) ? ST_ROUND : ST_LEN;
			ST_LEN: state_d = ST_ROUND;
			ST_EMIT: if (!ov_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (req_valid && req_data.byte_valid) begin
				buf_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= req_data.data_byte;
			end
			ST_PAD: begin
				// mark byte, zero the rest of the block
				for (int k = 0; k < 64; k++) begin
					if (k[5:0] == fill_q) buf_q[k/4][8*(k%4) +: 8] <= PAD_BYTE;
					else if (k[5:0] > fill_q) buf_q[k/4][8*(k%4) +: 8] <= 8'h00;
				end
			end
			ST_LEN: begin
				if (tail_q) begin
					for (int k = 0; k < 14; k++) buf_q[k] <= 32'h0;
				end
				buf_q[14] <= bits_q[31:0];
				buf_q[15] <= bits_q[63:32];
			end
			ST_EMIT: if (!ov_q) begin
				out_q.digest_low <= {h_q[1], h_q[0]};
				out_q.digest_high <= {h_q[3], h_q[2]};
			end
			default: ;
		endcase
		if (state_q == ST_ROUND) begin
			a_q <= d_q; b_q <= bnew; c_q <= b_q; d_q <= c_q;
		end else begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= 6'd0;
			bits_q <= 64'd0;
			idx_q <= 6'd0;
			fin_q <= 1'b0;
			len_q <= 1'b0;
			tail_q <= 1'b0;
			ov_q <= 1'b0;
			h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3;
		end else begin
			state_q <= state_d;
			if (ov_q && !stall) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (req_valid) begin
					if (req_data.byte_valid) begin
						fill_q <= fill_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
					fin_q <= req_data.last;
				end
				ST_ROUND: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) begin
						h_q[0] <= h_q[0] + d_q;
						h_q[1] <= h_q[1] + bnew;
						h_q[2] <= h_q[2] + b_q;
						h_q[3] <= h_q[3] + c_q;
						if (fin_q && !len_q) fin_q <= 1'b1;
					end
				end
				ST_PAD: begin
					// long tail: this block is not the length block, one more follows
					if (fill_q >= 6'd56) begin
						fill_q <= 6'd0;
						fin_q <= 1'b0;
						tail_q <= 1'b1;
					end else begin
						fin_q <= 1'b1;
					end
				end
				ST_LEN: begin
					len_q <= 1'b1;
					tail_q <= 1'b0;
				end
				ST_EMIT: if (!ov_q) begin
					ov_q <= 1'b1;
					len_q <= 1'b0;
					fin_q <= 1'b0;
					fill_q <= 6'd0;
					bits_q <= 64'd0;
					h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |=> (state_q == ST_ROUND || idx_q == 6'd0))
		else $error("round counter left mid-block");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_take)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && stall) |=> ov_q && $stable(out_q))
		else $error("digest dropped under stall");

endmodule
`default_nettype wire
